// ===== rtl/mdq_pkg.sv =====
// Shared types, codes and helpers for the message deque.
// No dependencies; every other file of the block imports this package.
package mdq_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int PAYLOAD_W = 64;
  localparam int LEN_W     = 4;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;
  localparam int MSZ_W     = 4;
  localparam int CAP_W     = 5;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Register indexes on the configuration port.
  localparam logic REG_MAX_LEN  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // Register reset values.
  localparam logic [MSZ_W-1:0] MAX_LEN_RESET  = 4'd8;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND   = 2'd0,
    CMD_URGENT = 2'd1,
    CMD_RECV   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // What one cell of the chain does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LOWER = 2'd2,
    CELL_FROM_UPPER = 2'd3
  } cell_op_e;

  // Raw configuration register contents.
  typedef struct packed {
    logic [MSZ_W-1:0] max_len;
    logic [CAP_W-1:0] capacity;
  } cfg_t;

  // Mask with the low n bytes set; n of eight or more gives all ones.
  function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [PAYLOAD_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_W / 8; b++) begin
      if (LEN_W'(b) < n) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/mdq_in_if.sv =====
// Command channel of the message deque: valid/ready plus the command fields.
// Depends on mdq_pkg for field widths.
interface mdq_in_if
  import mdq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [PAYLOAD_W-1:0] payload;
  logic [LEN_W-1:0]     length;

  modport source(output valid, cmd, payload, length, input ready);
  modport sink(input valid, cmd, payload, length, output ready);
endinterface

// ===== rtl/mdq_out_if.sv =====
// Result channel of the message deque: valid/ready plus the result fields.
// Depends on mdq_pkg for field widths.
interface mdq_out_if
  import mdq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [PAYLOAD_W-1:0] received;
  logic [LEN_W-1:0]     delivered_bytes;
  logic [OCC_W-1:0]     occupancy;

  modport source(output valid, status, received, delivered_bytes, occupancy, input ready);
  modport sink(input valid, status, received, delivered_bytes, occupancy, output ready);
endinterface

// ===== rtl/mdq_cell.sv =====
// One message slot of the deque chain; takes new data or a neighbor's word.
// Depends on mdq_pkg for the cell operation type.
module mdq_cell
  import mdq_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk,
  input  cell_op_e     op,
  input  logic [W-1:0] load_data,
  input  logic [W-1:0] lower_data,
  input  logic [W-1:0] upper_data,
  output logic [W-1:0] data_r
);

  logic [W-1:0] data_nxt;

  // Select the next word for this slot.
  always_comb begin
    case (op)
      CELL_LOAD:       data_nxt = load_data;
      CELL_FROM_LOWER: data_nxt = lower_data;
      CELL_FROM_UPPER: data_nxt = upper_data;
      default:         data_nxt = data_r;
    endcase
  end

  // Slot contents are payload and need no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/mdq_cfg.sv =====
// APB-style configuration registers: message size and capacity.
// Depends on mdq_pkg for register indexes, widths and reset values.
module mdq_cfg
  import mdq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Register writes in the access phase; word index taken from paddr[2].
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_len  <= MAX_LEN_RESET;
      cfg_r.capacity <= CAPACITY_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_MAX_LEN) begin
        cfg_r.max_len <= pwdata[MSZ_W-1:0];
      end else begin
        cfg_r.capacity <= pwdata[CAP_W-1:0];
      end
    end
  end

  // Read back the addressed register.
  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(cfg_r.capacity);
    end else begin
      prdata = APB_DW'(cfg_r.max_len);
    end
  end

endmodule

// ===== rtl/message_deque_with_urgent_insert.sv =====
// Message deque with urgent insert.
// Commands arrive on in_ch (valid/ready): send appends a message at the tail,
// urgent puts one at the head, receive takes the head message and returns up
// to min(length, message size) bytes, and clear discards all messages.
// Every command gives exactly one result transaction on out_ch: a status,
// the received bytes (zero above the delivered count), the delivered byte
// count and the number of messages held afterwards.
// Messages live in a row of DEPTH cells. Cell 0 is always the head; urgent
// shifts the row up one cell, receive shifts it down one cell, send loads
// the cell just past the last message.
// The result is registered when the command is accepted; the block takes one
// command per cycle, limited only by the single output register, which
// accepts a new command in the same cycle its held result is taken.
// If the receiver stalls, the result waits in the output register and in_ch
// stops accepting until it is taken.
// Synchronous reset empties the queue and loads message size 8 and capacity
// 16; slot contents are not cleared. The user must write the APB registers
// (message size at byte address 0, capacity at 4) only while idle, unchecked.
module message_deque_with_urgent_insert
  import mdq_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int MSG_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  mdq_in_if.sink            in_ch,
  mdq_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = 8 * MSG_BYTES;

  cfg_t             cfg;
  logic [MSZ_W-1:0] msz;
  logic [CW-1:0]    cap;

  logic [CW-1:0] count_r, count_nxt;
  logic [DW-1:0] cell_q [DEPTH];
  cell_op_e      cell_op [DEPTH];
  logic [DW-1:0] new_data;

  logic                 accept;
  cmd_e                 cmd;
  logic                 cmd_ok;
  status_e              status_nxt;
  logic [LEN_W-1:0]     deliv_nxt;
  logic [PAYLOAD_W-1:0] recv_nxt;

  logic                 out_valid_r;
  status_e              status_r;
  logic [PAYLOAD_W-1:0] received_r;
  logic [LEN_W-1:0]     deliv_r;
  logic [OCC_W-1:0]     occ_r;

  // Configuration registers.
  mdq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective message size and capacity, clamped to what the store holds.
  always_comb begin
    if (cfg.max_len > MSZ_W'(MSG_BYTES)) begin
      msz = MSZ_W'(MSG_BYTES);
    end else begin
      msz = cfg.max_len;
    end
    if (32'(cfg.capacity) > DEPTH) begin
      cap = CW'(DEPTH);
    end else begin
      cap = CW'(cfg.capacity);
    end
  end

  // Handshake: a new command enters when the output register is free or drains.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_e'(in_ch.cmd);
  assign new_data    = DW'(in_ch.payload & byte_mask(in_ch.length));

  // Command decode: status, delivered bytes and the new message count.
  always_comb begin
    status_nxt = ST_OK;
    deliv_nxt  = '0;
    recv_nxt   = '0;
    count_nxt  = count_r;
    cmd_ok     = 1'b0;
    case (cmd)
      CMD_SEND, CMD_URGENT: begin
        if (in_ch.length > msz) begin
          status_nxt = ST_TOO_LONG;
        end else if (count_r >= cap) begin
          status_nxt = ST_FULL;
        end else begin
          cmd_ok    = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_RECV: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          cmd_ok    = 1'b1;
          deliv_nxt = (in_ch.length < msz) ? in_ch.length : msz;
          recv_nxt  = PAYLOAD_W'(cell_q[0]) & byte_mask(deliv_nxt);
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  // Per-cell operation: load at the tail, shift up for urgent, down for receive.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept && cmd_ok) begin
        case (cmd)
          CMD_SEND: begin
            if (count_r == CW'(i)) begin
              cell_op[i] = CELL_LOAD;
            end
          end
          CMD_URGENT: cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_LOWER;
          CMD_RECV:   cell_op[i] = (i == DEPTH - 1) ? CELL_HOLD : CELL_FROM_UPPER;
          default:    cell_op[i] = CELL_HOLD;
        endcase
      end
    end
  end

  // The chain of message cells; the ends take their own word as neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mdq_cell #(
      .W (DW)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op[g]),
      .load_data  (new_data),
      .lower_data (cell_q[(g == 0) ? 0 : g - 1]),
      .upper_data (cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .data_r     (cell_q[g])
    );
  end

  // Message count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload, captured with each accepted command.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      received_r <= recv_nxt;
      deliv_r    <= deliv_nxt;
      occ_r      <= OCC_W'(count_nxt);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.received        = received_r;
  assign out_ch.delivered_bytes = deliv_r;
  assign out_ch.occupancy       = occ_r;

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("message count exceeds store depth");

  // A receive from a non-empty queue reports success in the next cycle.
  a_recv_ok: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_RECV && count_r != '0 |=> out_valid_r && status_r == ST_OK)
    else $error("receive from non-empty queue did not succeed");

  // Delivered bytes only come with a successful status.
  a_deliv_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && deliv_r != '0 |-> status_r == ST_OK)
    else $error("bytes delivered with a failing status");

  // Received bytes above the delivered count are zero.
  a_recv_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (received_r & ~byte_mask(deliv_r)) == '0)
    else $error("received bytes beyond delivered count");

  // A clear command empties the queue.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd == CMD_CLEAR |=> count_r == '0 && occ_r == '0)
    else $error("clear did not empty the queue");

endmodule

// ===== sim/message_deque_with_urgent_insert_tb.sv =====
// Self-checking testbench for the message deque with urgent insert.
// Depends on mdq_pkg, the mdq_in_if and mdq_out_if interfaces and the block's RTL.
// A software deque predicts every reply; directed tests come first, then random traffic.
module message_deque_with_urgent_insert_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mdq_pkg::*;

  localparam int MAX_BYTES        = 8;
  localparam int SLOTS            = 16;
  localparam int RANDOM_ITEMS     = 750;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = RANDOM_ITEMS / PHASES;
  localparam int RUN_LIMIT        = 300000;

  // One reply transaction as the block should produce it.
  typedef struct {
    status_e              status;
    logic [PAYLOAD_W-1:0] received;
    logic [LEN_W-1:0]     delivered;
    logic [OCC_W-1:0]     occupancy;
  } reply_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mdq_in_if  cmd_if();
  mdq_out_if res_if();

  // Shadow of the block: register copies and the messages it holds, head first.
  logic [MSZ_W-1:0]     max_len_reg;
  logic [CAP_W-1:0]     capacity_reg;
  logic [PAYLOAD_W-1:0] held_msgs[$];
  reply_t               replies_due[$];

  int mismatches     = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int settings_count = 0;
  int cmd_counts[4]    = '{default: 0};
  int status_counts[4] = '{default: 0};

  message_deque_with_urgent_insert dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (cmd_if),
    .out_ch  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Low n bytes set; eight or more gives all ones.
  function automatic logic [PAYLOAD_W-1:0] low_bytes(input int n);
    if (n >= MAX_BYTES) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int size_limit();
    return (max_len_reg > MAX_BYTES) ? MAX_BYTES : int'(max_len_reg);
  endfunction

  // Applies one command to the shadow deque and returns the reply it causes.
  function automatic reply_t predict_reply(input cmd_e op, input logic [PAYLOAD_W-1:0] data,
                                           input logic [LEN_W-1:0] len);
    reply_t r;
    int     size_lim;
    int     cap_lim;
    size_lim    = size_limit();
    cap_lim     = (capacity_reg > SLOTS) ? SLOTS : int'(capacity_reg);
    r.status    = ST_OK;
    r.received  = '0;
    r.delivered = '0;
    case (op)
      CMD_SEND, CMD_URGENT: begin
        // The length check wins over the full check; a failed insert changes nothing.
        if (len > size_lim) begin
          r.status = ST_TOO_LONG;
        end else if (held_msgs.size() >= cap_lim) begin
          r.status = ST_FULL;
        end else if (op == CMD_SEND) begin
          held_msgs.push_back(data & low_bytes(len));
        end else begin
          held_msgs.push_front(data & low_bytes(len));
        end
      end
      CMD_RECV: begin
        if (held_msgs.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.delivered = (len < size_lim) ? len : LEN_W'(size_lim);
          r.received  = held_msgs.pop_front() & low_bytes(r.delivered);
        end
      end
      default: begin
        held_msgs.delete();
      end
    endcase
    r.occupancy = OCC_W'(held_msgs.size());
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [PAYLOAD_W-1:0] want_v,
                                      input logic [PAYLOAD_W-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want_v, got_v);
    end
  endfunction

  // Predict on every accepted command, then check every accepted reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      if (cmd_if.valid && cmd_if.ready) begin
        want = predict_reply(cmd_e'(cmd_if.cmd), cmd_if.payload, cmd_if.length);
        replies_due.push_back(want);
        cmd_counts[cmd_if.cmd]++;
        status_counts[want.status]++;
      end
      if (res_if.valid && res_if.ready) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          $display("%0t: reply with none expected: status %h, received %h, occupancy %h",
                   $time, res_if.status, res_if.received, res_if.occupancy);
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("received", want.received, res_if.received);
          check_field("delivered_bytes", want.delivered, res_if.delivered_bytes);
          check_field("occupancy", want.occupancy, res_if.occupancy);
        end
      end
    end
  end

  // Receiver: switches at random between stall patterns.
  initial begin
    stall_mode_e mode;
    int          left;
    res_if.ready <= 1'b0;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 150);
      end
      left--;
      case (mode)
        STALL_NONE:     res_if.ready <= 1'b1;
        STALL_RANDOM:   res_if.ready <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: res_if.ready <= (left % 4 != 0);
        default:        res_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding.",
               cycle_count, replies_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one command transaction; the sender works in bursts with gaps between them.
  task automatic issue(input cmd_e op, input logic [PAYLOAD_W-1:0] data,
                       input logic [LEN_W-1:0] len);
    cmd_if.valid   <= 1'b1;
    cmd_if.cmd     <= op;
    cmd_if.payload <= data;
    cmd_if.length  <= len;
    do @(posedge clk); while (!cmd_if.ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  // Holds the sender until every expected reply has been taken.
  task automatic drain();
    if (cmd_if.valid) cmd_if.valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Register write over APB: setup cycle, then access cycle; only while idle.
  task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MAX_LEN) begin
      max_len_reg = value[MSZ_W-1:0];
    end else begin
      capacity_reg = value[CAP_W-1:0];
    end
  endtask

  // Reset settings: empty receive, masking of short messages, urgent order, long lengths.
  task automatic test_basic_commands();
    issue(CMD_RECV, rand_payload(), 4'd8);
    issue(CMD_SEND, '1, 4'd8);
    issue(CMD_SEND, rand_payload(), 4'd1);
    issue(CMD_SEND, '1, 4'd0);
    issue(CMD_URGENT, rand_payload(), 4'd8);
    issue(CMD_SEND, rand_payload(), 4'd9);
    issue(CMD_URGENT, rand_payload(), 4'd15);
    issue(CMD_RECV, rand_payload(), 4'd15);
    issue(CMD_RECV, rand_payload(), 4'd0);
    issue(CMD_RECV, rand_payload(), 4'd3);
    issue(CMD_CLEAR, rand_payload(), 4'd5);
    issue(CMD_RECV, rand_payload(), 4'd8);
  endtask

  // Small capacity, too-long taking precedence over full, capacity lowered below occupancy.
  task automatic test_full_queue();
    write_register(REG_CAPACITY, 2);
    settings_count++;
    issue(CMD_SEND, rand_payload(), 4'd3);
    issue(CMD_URGENT, rand_payload(), 4'd5);
    issue(CMD_SEND, rand_payload(), 4'd2);
    issue(CMD_URGENT, rand_payload(), 4'd15);
    write_register(REG_CAPACITY, 1);
    settings_count++;
    issue(CMD_RECV, rand_payload(), 4'd8);
    issue(CMD_SEND, rand_payload(), 4'd4);
    issue(CMD_RECV, rand_payload(), 4'd8);
    issue(CMD_SEND, rand_payload(), 4'd4);
    issue(CMD_CLEAR, rand_payload(), 4'd0);
  endtask

  // Message size zero and above the maximum, capacity zero and above the depth.
  task automatic test_size_limits();
    write_register(REG_MAX_LEN, 0);
    settings_count++;
    issue(CMD_SEND, '1, 4'd0);
    issue(CMD_URGENT, rand_payload(), 4'd1);
    issue(CMD_RECV, rand_payload(), 4'd8);
    write_register(REG_MAX_LEN, 15);
    write_register(REG_CAPACITY, 31);
    settings_count++;
    issue(CMD_SEND, rand_payload(), 4'd8);
    issue(CMD_SEND, rand_payload(), 4'd9);
    issue(CMD_RECV, rand_payload(), 4'd15);
    write_register(REG_CAPACITY, 0);
    settings_count++;
    issue(CMD_SEND, rand_payload(), 4'd0);
    issue(CMD_URGENT, rand_payload(), 4'd0);
  endtask

  // Random traffic over several settings; the fill bias drifts so the queue
  // swings between empty and full.
  task automatic test_random_traffic();
    int               sz;
    int               cap;
    int               fill_pct;
    int               roll;
    cmd_e             op;
    logic [LEN_W-1:0] len;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       begin sz = 8;  cap = 16; end
        1:       begin sz = 1;  cap = 1;  end
        2:       begin sz = 15; cap = 31; end
        3:       begin sz = 8;  cap = 3;  end
        4:       begin sz = 0;  cap = 4;  end
        5:       begin sz = 4;  cap = 16; end
        default: begin sz = $urandom_range(0, 15); cap = $urandom_range(0, 31); end
      endcase
      write_register(REG_MAX_LEN, sz);
      write_register(REG_CAPACITY, cap);
      settings_count++;
      fill_pct = 50;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i % 25 == 0) fill_pct = $urandom_range(20, 85);
        // Hold off mid-phase, and now and then at random, until the block has answered everything.
        if (i == ITEMS_PER_PHASE / 2 || $urandom_range(0, 79) == 0) drain();
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          op = CMD_CLEAR;
        end else if (roll < fill_pct) begin
          op = ($urandom_range(0, 2) == 0) ? CMD_URGENT : CMD_SEND;
        end else begin
          op = CMD_RECV;
        end
        if ($urandom_range(0, 6) == 0) begin
          len = LEN_W'($urandom_range(0, 15));
        end else begin
          len = LEN_W'($urandom_range(0, size_limit()));
        end
        issue(op, rand_payload(), len);
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.cmd     <= CMD_SEND;
    cmd_if.payload <= '0;
    cmd_if.length  <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    max_len_reg    = MAX_LEN_RESET;
    capacity_reg   = CAPACITY_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_commands();
    test_full_queue();
    test_size_limits();
    test_random_traffic();

    drain();
    repeat (5) @(posedge clk);

    $display("Covered %0d commands (send %0d, urgent %0d, receive %0d, clear %0d)",
             cmd_counts[CMD_SEND] + cmd_counts[CMD_URGENT] + cmd_counts[CMD_RECV] +
             cmd_counts[CMD_CLEAR], cmd_counts[CMD_SEND], cmd_counts[CMD_URGENT],
             cmd_counts[CMD_RECV], cmd_counts[CMD_CLEAR]);
    $display("over %0d settings; replies ok %0d, too long %0d, full %0d, empty %0d.",
             settings_count, status_counts[ST_OK], status_counts[ST_TOO_LONG],
             status_counts[ST_FULL], status_counts[ST_EMPTY]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
